/* src/mhmm_pkg.sv */
package mhmm_pkg;

	localparam int PIXEL_BITS = 12;
	localparam int MAX_DIM    = 4096;

	localparam int NUM_BINS  = 1 << PIXEL_BITS;
	localparam int PIX_W     = 16;
	localparam int DIM_W     = 13;
	localparam int DEPTH_W   = 5;
	localparam int BIN_W     = 25;
	localparam int SUM_W     = 40;
	localparam int POS_W     = 24;
	localparam int SIZE_W    = 25;
	localparam int MEAN_W    = 24;
	localparam int IDX_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;
	localparam int FRAC_W    = 8;
	localparam int DVD_W     = SUM_W + FRAC_W;

	localparam logic [DIM_W-1:0]   RESET_WIDTH  = DIM_W'(640);
	localparam logic [DIM_W-1:0]   RESET_HEIGHT = DIM_W'(480);
	localparam logic [DEPTH_W-1:0] RESET_DEPTH  = DEPTH_W'(8);
	localparam logic [PIX_W-1:0]   LOW_TOP_BIN  = PIX_W'(255);

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_BIT_DEPTH    = 2'd2,
		REG_USE_MASK     = 2'd3
	} reg_idx_t;

	localparam logic KIND_STATS = 1'b0;
	localparam logic KIND_BIN   = 1'b1;

	typedef struct packed {
		logic latch_in;
		logic clr_stats;
		logic clr_step;
		logic mem_rd;
		logic sel_bin;
		logic pix_update;
		logic div_start;
		logic load_stats;
		logic load_bin;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic frame_end;
		logic div_busy;
		logic out_full;
	} status_t;

	// Depths of eight bits or fewer all share the 256-bin range.
	function automatic logic [PIX_W-1:0] top_bin(input logic [DEPTH_W-1:0] depth);
		logic [DEPTH_W-1:0] d;
		logic [PIX_W:0]     t;
		begin
			d = (depth > DEPTH_W'(PIXEL_BITS)) ? DEPTH_W'(PIXEL_BITS) : depth;
			t = ((PIX_W+1)'(1) << d) - (PIX_W+1)'(1);
			top_bin = (d <= DEPTH_W'(8)) ? LOW_TOP_BIN : t[PIX_W-1:0];
		end
	endfunction

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		begin
			if (v == '0) begin
				sat_dim = DIM_W'(1);
			end else if (v > DIM_W'(MAX_DIM)) begin
				sat_dim = DIM_W'(MAX_DIM);
			end else begin
				sat_dim = v;
			end
		end
	endfunction

endpackage

/* src/mhmm_div.sv */
module mhmm_div
	import mhmm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  sum,
	input  logic [SIZE_W-1:0] size,
	output logic              busy,
	output logic [MEAN_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0]  dq_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;

	logic [SIZE_W:0] trial;
	logic            fits;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, dq_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= {sum, FRAC_W'(0)};
			rem_q <= '0;
			dvs_q <= size;
		end else if (busy_q) begin
			rem_q <= fits ? SIZE_W'(trial - {1'b0, dvs_q}) : trial[SIZE_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = (|dq_q[DVD_W-1:MEAN_W]) ? '1 : dq_q[MEAN_W-1:0];

endmodule

/* src/mhmm_dp.sv */
module mhmm_dp
	import mhmm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              sts,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 pixel_mask,
	input  logic [IDX_W-1:0]     bin_index,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 result_kind,
	output logic [BIN_W-1:0]     bin_count,
	output logic [PIX_W-1:0]     min_value,
	output logic [PIX_W-1:0]     max_value,
	output logic [MEAN_W-1:0]    mean_value
);

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               use_mask_q;
	logic [SIZE_W-1:0]  size_q;

	logic [PIX_W-1:0] g_q;
	logic             counted_q;
	logic [IDX_W-1:0] idx_q;

	logic [BIN_W-1:0] bin_mem [NUM_BINS];
	logic [BIN_W-1:0] rdata_q;
	logic [PIXEL_BITS-1:0] clr_addr_q;
	logic [PIXEL_BITS-1:0] mem_addr;

	logic [PIX_W-1:0] min_q;
	logic [PIX_W-1:0] max_q;
	logic [SUM_W-1:0] sum_q;
	logic [POS_W-1:0] pos_q;
	logic             any_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [BIN_W-1:0]  count_q;
	logic [PIX_W-1:0]  minv_q;
	logic [PIX_W-1:0]  maxv_q;
	logic [MEAN_W-1:0] mean_q;

	logic [PIX_W-1:0]  top;
	logic [PIX_W-1:0]  g_in;
	logic [SUM_W:0]    sum_add;
	logic [MEAN_W-1:0] quotient;
	logic              div_busy;
	logic [2*DIM_W-1:0] size_prod;

	assign top       = top_bin(depth_q);
	assign g_in      = (pixel_value > top) ? top : pixel_value;
	assign sum_add   = {1'b0, sum_q} + (SUM_W+1)'(g_q);
	assign size_prod = sat_dim(width_q) * sat_dim(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= RESET_WIDTH;
			height_q   <= RESET_HEIGHT;
			depth_q    <= RESET_DEPTH;
			use_mask_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FRAME_WIDTH:  width_q    <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q   <= cfg_data[DIM_W-1:0];
				REG_BIT_DEPTH:    depth_q    <= cfg_data[DEPTH_W-1:0];
				REG_USE_MASK:     use_mask_q <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Registered size; user changes configuration only in idle, unchecked.
	always_ff @(posedge clk) begin
		size_q <= size_prod[SIZE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			g_q       <= g_in;
			counted_q <= !use_mask_q || pixel_mask;
			idx_q     <= bin_index;
		end
	end

	always_comb begin
		if (cmd.clr_step) begin
			mem_addr = clr_addr_q;
		end else if (cmd.sel_bin) begin
			mem_addr = idx_q[PIXEL_BITS-1:0];
		end else begin
			mem_addr = g_q[PIXEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			bin_mem[mem_addr] <= '0;
		end else if (cmd.pix_update && counted_q) begin
			bin_mem[mem_addr] <= (&rdata_q) ? rdata_q : rdata_q + BIN_W'(1);
		end
		if (cmd.mem_rd) begin
			rdata_q <= bin_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= clr_addr_q + PIXEL_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= LOW_TOP_BIN;
			max_q <= '0;
			sum_q <= '0;
			pos_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.clr_stats) begin
			min_q <= top;
			max_q <= '0;
			sum_q <= '0;
			pos_q <= '0;
			any_q <= 1'b0;
		end else if (cmd.pix_update) begin
			if (counted_q) begin
				sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
				if (!any_q || g_q < min_q) begin
					min_q <= g_q;
				end
				if (!any_q || g_q > max_q) begin
					max_q <= g_q;
				end
				any_q <= 1'b1;
			end
			pos_q <= sts.frame_end ? '0 : pos_q + POS_W'(1);
		end
	end

	mhmm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.sum      (sum_q),
		.size     (size_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_stats || cmd.load_bin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_stats) begin
			kind_q  <= KIND_STATS;
			count_q <= '0;
			minv_q  <= any_q ? min_q : top;
			maxv_q  <= any_q ? max_q : '0;
			mean_q  <= quotient;
		end else if (cmd.load_bin) begin
			kind_q  <= KIND_BIN;
			count_q <= ({1'b0, idx_q} < (IDX_W+1)'(NUM_BINS)) ? rdata_q : '0;
			minv_q  <= '0;
			maxv_q  <= '0;
			mean_q  <= '0;
		end
	end

	assign sts.clr_last  = &clr_addr_q;
	assign sts.frame_end = ({1'b0, pos_q} + SIZE_W'(1)) >= size_q;
	assign sts.div_busy  = div_busy;
	assign sts.out_full  = out_valid_q;

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign bin_count   = count_q;
	assign min_value   = minv_q;
	assign max_value   = maxv_q;
	assign mean_value  = mean_q;

endmodule

/* src/mhmm_ctrl.sv */
module mhmm_ctrl
	import mhmm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic       out_ready,
	input  status_t    sts,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PIX_RD,
		S_PIX_WR,
		S_DIV_GO,
		S_DIV_RUN,
		S_BIN_RD,
		S_BIN_OUT
	} state_t;

	state_t state_q;
	logic   accept;
	logic   out_free;
	op_t    op;

	assign op       = op_t'(opcode);
	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !sts.out_full || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.latch_in  = accept;
		cmd.clr_stats = accept && op == OP_CLEAR;
		unique case (state_q)
			S_CLEAR:   cmd.clr_step   = 1'b1;
			S_PIX_RD:  cmd.mem_rd     = 1'b1;
			S_PIX_WR:  cmd.pix_update = 1'b1;
			S_DIV_GO:  cmd.div_start  = 1'b1;
			S_DIV_RUN: cmd.load_stats = !sts.div_busy && out_free;
			S_BIN_RD: begin
				cmd.mem_rd  = 1'b1;
				cmd.sel_bin = 1'b1;
			end
			S_BIN_OUT: cmd.load_bin   = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_PIXEL: state_q <= S_PIX_RD;
							OP_READ:  state_q <= S_BIN_RD;
							OP_CLEAR: state_q <= S_CLEAR;
							OP_NONE:  state_q <= S_IDLE;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_PIX_RD: state_q <= S_PIX_WR;
				S_PIX_WR: state_q <= sts.frame_end ? S_DIV_GO : S_IDLE;
				S_DIV_GO: state_q <= S_DIV_RUN;
				S_DIV_RUN: begin
					if (cmd.load_stats) begin
						state_q <= S_IDLE;
					end
				end
				S_BIN_RD: state_q <= S_BIN_OUT;
				S_BIN_OUT: begin
					if (cmd.load_bin) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A finished result must never overwrite one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_stats || cmd.load_bin) |-> (!sts.out_full || out_ready))
		else $error("result loaded over a pending one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && sts.clr_last) |=> (state_q == S_IDLE))
		else $error("clearing pass did not end on the last bin");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIX_WR && !sts.frame_end) |=> (state_q == S_IDLE))
		else $error("pixel without frame end did not return to idle");
`endif

endmodule

/* src/mono_histogram_min_max_mean.sv */
// Pixel request: accepted in idle, bin read and written back before the next is accepted.
// Last pixel of a frame: the mean divider runs; the result loads once the output is free.
// Bin read request: read, then loaded when the output is free. Clear request: every bin.
// A result waits in the output register while the next request is accepted.
// Reset: asynchronous, active low; it restores the register defaults and then runs a
// clearing pass over the bin memory, during which no request is accepted.
module mono_histogram_min_max_mean
	import mhmm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 pixel_mask,
	input  logic [IDX_W-1:0]     bin_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 result_kind,
	output logic [BIN_W-1:0]     bin_count,
	output logic [PIX_W-1:0]     min_value,
	output logic [PIX_W-1:0]     max_value,
	output logic [MEAN_W-1:0]    mean_value
);

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	mhmm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mhmm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_value (pixel_value),
		.pixel_mask  (pixel_mask),
		.bin_index   (bin_index),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.result_kind (result_kind),
		.bin_count   (bin_count),
		.min_value   (min_value),
		.max_value   (max_value),
		.mean_value  (mean_value)
	);

endmodule
